/* hw/rtl/gcdb_pkg.sv */
package gcdb_pkg;

  typedef logic signed [33:0] fx_t;

  localparam int SQRT_BITS = 31;
  localparam fx_t CORDIC_GAIN = 34'sd652032874;
  localparam fx_t PH_HALF_FX = 34'sd2147483648;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic [15:0] central_angle;
    logic [15:0] initial_bearing;
    logic [15:0] initial_azimuth;
    logic [15:0] final_bearing;
  } result_t;

  function automatic fx_t mul30(fx_t a, fx_t b);
    logic signed [67:0] p;
    p = a * b;
    p = p + 68'sd536870912;
    return fx_t'(p >>> 30);
  endfunction

endpackage

/* hw/rtl/great_circle_distance_bearing.sv */
// Haversine distance and bearings from a programmable reference point to a
// stream of target points, all angles in binary units of 2^ANGLE_BITS per
// turn. The pipeline takes one beat per cycle while the output skid entry
// is empty, and each result passes through two rotation/vectoring CORDIC
// chains and a 31-stage square root.
// A two-entry output stage keeps the pipeline moving for one beat of
// downstream stall. Reference registers: latitude at 0x0, longitude at 0x4.
module great_circle_distance_bearing
  import gcdb_pkg::*;
#(
  parameter int CORDIC_STAGES = 18,
  parameter int ANGLE_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // target_latitude [15:0], target_longitude [31:16]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // central_angle [15:0], initial_bearing [31:16],
  // initial_azimuth [47:32], final_bearing [63:48]
  output logic [63:0] m_axis_tdata
);

  localparam int PH_SHIFT = 32 - ANGLE_BITS;
  localparam int LAT = 2 * CORDIC_STAGES + 7 + SQRT_BITS;
  localparam logic [32:0] RND = (33'd1 << PH_SHIFT) >> 1;
  localparam logic [15:0] QTR_UNITS = 16'(64'd1 << (ANGLE_BITS - 2));

  function automatic logic [15:0] to_units(logic [31:0] p);
    logic [32:0] s;
    s = {1'b0, p} + RND;
    s = s >> PH_SHIFT;
    return s[15:0];
  endfunction

  logic [15:0] ref_latitude;
  logic [15:0] ref_longitude;
  logic        en;
  logic [LAT-1:0] vld;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_latitude  <= '0;
      ref_longitude <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        ref_longitude <= pwdata[15:0];
      end else begin
        ref_latitude <= pwdata[15:0];
      end
    end
  end

  assign prdata = paddr[2] ? {16'd0, ref_longitude} : {16'd0, ref_latitude};

  // Phase setup, one turn = 2^32.
  logic [31:0] plat1, plat2, plon1, plon2, dlon, hlat, hlon;

  always_comb begin
    plat1 = {{16{ref_latitude[15]}}, ref_latitude} << PH_SHIFT;
    plat2 = {{16{s_axis_tdata[15]}}, s_axis_tdata[15:0]} << PH_SHIFT;
    plon1 = {16'd0, ref_longitude} << PH_SHIFT;
    plon2 = {16'd0, s_axis_tdata[31:16]} << PH_SHIFT;
    dlon  = plon2 - plon1;
    hlat  = (plat2 - plat1) >> 1;
    hlon  = dlon >> 1;
  end

  fx_t c1, s1, c2, s2, cd, sd, chl, shl, chn, shn;

  gcdb_rotate #(.STAGES(CORDIC_STAGES)) u_rot_lat1 (
    .clk(clk), .en(en), .phase(plat1), .cos_out(c1), .sin_out(s1));
  gcdb_rotate #(.STAGES(CORDIC_STAGES)) u_rot_lat2 (
    .clk(clk), .en(en), .phase(plat2), .cos_out(c2), .sin_out(s2));
  gcdb_rotate #(.STAGES(CORDIC_STAGES)) u_rot_dlon (
    .clk(clk), .en(en), .phase(dlon), .cos_out(cd), .sin_out(sd));
  gcdb_rotate #(.STAGES(CORDIC_STAGES)) u_rot_hlat (
    .clk(clk), .en(en), .phase(hlat), .cos_out(chl), .sin_out(shl));
  gcdb_rotate #(.STAGES(CORDIC_STAGES)) u_rot_hlon (
    .clk(clk), .en(en), .phase(hlon), .cos_out(chn), .sin_out(shn));

  // Product stages.
  fx_t p_shl2, p_c12, p_shn2, p_ya1, p_t1, p_s1c2, p_ya2, p_t2, p_s2c1, p_cd;
  fx_t q_shl2, q_hav, q_r1, q_r2, q_ya1, q_t1, q_ya2, q_t2;
  logic [30:0]        hav;
  logic signed [34:0] xa1, ya1, xa2, ya2;
  logic signed [34:0] hav_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      p_shl2 <= mul30(shl, shl);
      p_c12  <= mul30(c1, c2);
      p_shn2 <= mul30(shn, shn);
      p_ya1  <= mul30(sd, c2);
      p_t1   <= mul30(c1, s2);
      p_s1c2 <= mul30(s1, c2);
      p_ya2  <= mul30(-sd, c1);
      p_t2   <= mul30(c2, s1);
      p_s2c1 <= mul30(s2, c1);
      p_cd   <= cd;

      q_shl2 <= p_shl2;
      q_hav  <= mul30(p_c12, p_shn2);
      q_r1   <= mul30(p_s1c2, p_cd);
      q_r2   <= mul30(p_s2c1, p_cd);
      q_ya1  <= p_ya1;
      q_t1   <= p_t1;
      q_ya2  <= p_ya2;
      q_t2   <= p_t2;

      if (hav_sum < 0) begin
        hav <= '0;
      end else if (hav_sum > 35'sd1073741824) begin
        hav <= 31'd1073741824;
      end else begin
        hav <= hav_sum[30:0];
      end
      xa1 <= 35'(q_t1) - 35'(q_r1);
      ya1 <= 35'(q_ya1);
      xa2 <= 35'(q_t2) - 35'(q_r2);
      ya2 <= 35'(q_ya2);
    end
  end

  assign hav_sum = 35'(q_shl2) + 35'(q_hav);

  // Central angle: square roots, then atan2.
  logic [SQRT_BITS-1:0] sa, sc;
  logic [30:0]          hav_c;

  assign hav_c = 31'd1073741824 - hav;

  gcdb_isqrt #(.ROOT_BITS(SQRT_BITS)) u_sqrt_a (
    .clk(clk), .en(en), .radicand({hav, 30'd0}), .root(sa));
  gcdb_isqrt #(.ROOT_BITS(SQRT_BITS)) u_sqrt_c (
    .clk(clk), .en(en), .radicand({hav_c, 30'd0}), .root(sc));

  fx_t ang_c, ang_i, ang_f;

  gcdb_vector #(.STAGES(CORDIC_STAGES), .IN_W(35)) u_vec_central (
    .clk(clk), .en(en), .x_in(35'(sc)), .y_in(35'(sa)), .angle(ang_c));
  gcdb_vector #(.STAGES(CORDIC_STAGES), .IN_W(35)) u_vec_initial (
    .clk(clk), .en(en), .x_in(xa1), .y_in(ya1), .angle(ang_i));
  gcdb_vector #(.STAGES(CORDIC_STAGES), .IN_W(35)) u_vec_final (
    .clk(clk), .en(en), .x_in(xa2), .y_in(ya2), .angle(ang_f));

  // Bearings finish earlier than the central angle; hold them back.
  logic [31:0] ib_dly [SQRT_BITS];
  logic [31:0] fb_dly [SQRT_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      ib_dly[0] <= ang_i[31:0];
      fb_dly[0] <= ang_f[31:0] + 32'h8000_0000;
      for (int k = 1; k < SQRT_BITS; k++) begin
        ib_dly[k] <= ib_dly[k-1];
        fb_dly[k] <= fb_dly[k-1];
      end
    end
  end

  logic [30:0] ang_cl;
  logic [15:0] ib_units;
  result_t     res;
  result_t     res_out;
  result_t     skid;
  logic        skid_vld;

  always_comb begin
    if (ang_c < 0) begin
      ang_cl = '0;
    end else if (ang_c > 34'sd1073741824) begin
      ang_cl = 31'd1073741824;
    end else begin
      ang_cl = ang_c[30:0];
    end
    ib_units = to_units(ib_dly[SQRT_BITS-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.central_angle   <= to_units({ang_cl, 1'b0});
      res.initial_bearing <= ib_units;
      res.initial_azimuth <= QTR_UNITS - ib_units;
      res.final_bearing   <= to_units(fb_dly[SQRT_BITS-1]);
    end
  end

  // Valid bits and output skid stage.
  assign en = !skid_vld;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_vld      <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_vld) begin
        m_axis_tvalid <= 1'b1;
        skid_vld      <= 1'b0;
      end else begin
        m_axis_tvalid <= vld[LAT-1];
      end
    end else if (en && vld[LAT-1]) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      res_out <= skid_vld ? skid : res;
    end else if (en && vld[LAT-1]) begin
      skid <= res;
    end
  end

  assign m_axis_tdata = {res_out.final_bearing, res_out.initial_azimuth,
                         res_out.initial_bearing, res_out.central_angle};

endmodule

/* hw/rtl/gcdb_rotate.sv */
module gcdb_rotate
  import gcdb_pkg::*;
#(
  parameter int STAGES = 18
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] phase,
  output fx_t         cos_out,
  output fx_t         sin_out
);

  fx_t  x [STAGES+1];
  fx_t  y [STAGES+1];
  fx_t  z [STAGES+1];
  logic neg [STAGES+1];

  logic [31:0] folded;
  logic        flip;

  always_comb begin
    flip   = (phase - 32'h4000_0000) < 32'h8000_0000;
    folded = flip ? phase - 32'h8000_0000 : phase;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]   <= CORDIC_GAIN;
      y[0]   <= '0;
      z[0]   <= fx_t'($signed(folded));
      neg[0] <= flip;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam int K = i & 31;
    localparam fx_t ATN = fx_t'({2'b00, ATAN_TAB[K]});
    always_ff @(posedge clk) begin
      if (en) begin
        neg[i+1] <= neg[i];
        if (!z[i][33]) begin
          x[i+1] <= x[i] - (y[i] >>> K);
          y[i+1] <= y[i] + (x[i] >>> K);
          z[i+1] <= z[i] - ATN;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> K);
          y[i+1] <= y[i] - (x[i] >>> K);
          z[i+1] <= z[i] + ATN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= neg[STAGES] ? -x[STAGES] : x[STAGES];
      sin_out <= neg[STAGES] ? -y[STAGES] : y[STAGES];
    end
  end

endmodule

/* hw/rtl/gcdb_isqrt.sv */
module gcdb_isqrt
  import gcdb_pkg::*;
#(
  parameter int ROOT_BITS = 31
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [2*ROOT_BITS-2:0]   radicand,
  output logic [ROOT_BITS-1:0]     root
);

  localparam int RW = 2 * ROOT_BITS;

  logic [RW-1:0]        rem [ROOT_BITS];
  logic [ROOT_BITS-1:0] acc [ROOT_BITS];

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
    localparam int B = ROOT_BITS - 1 - j;
    logic [RW-1:0]        rin;
    logic [ROOT_BITS-1:0] ain;
    logic [RW-1:0]        trial;
    if (j == 0) begin : g_first
      assign rin = {1'b0, radicand};
      assign ain = '0;
    end else begin : g_next
      assign rin = rem[j-1];
      assign ain = acc[j-1];
    end
    assign trial = (RW'(ain) << (B + 1)) | (RW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          rem[j] <= rin - trial;
          acc[j] <= ain | (ROOT_BITS'(1) << B);
        end else begin
          rem[j] <= rin;
          acc[j] <= ain;
        end
      end
    end
  end

  assign root = acc[ROOT_BITS-1];

endmodule

/* hw/rtl/gcdb_vector.sv */
module gcdb_vector
  import gcdb_pkg::*;
#(
  parameter int STAGES = 18,
  parameter int IN_W   = 35
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [IN_W-1:0] x_in,
  input  logic signed [IN_W-1:0] y_in,
  output fx_t                    angle
);

  localparam int VW = IN_W + 2;

  logic signed [VW-1:0] x [STAGES+1];
  logic signed [VW-1:0] y [STAGES+1];
  fx_t                  z [STAGES+1];
  logic                 zf [STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[IN_W-1]) begin
        x[0] <= -VW'(x_in);
        y[0] <= -VW'(y_in);
        z[0] <= y_in[IN_W-1] ? -PH_HALF_FX : PH_HALF_FX;
      end else begin
        x[0] <= VW'(x_in);
        y[0] <= VW'(y_in);
        z[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam int K = i & 31;
    localparam fx_t ATN = fx_t'({2'b00, ATAN_TAB[K]});
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (y[i] > 0) begin
          x[i+1] <= x[i] + (y[i] >>> K);
          y[i+1] <= y[i] - (x[i] >>> K);
          z[i+1] <= z[i] + ATN;
        end else begin
          x[i+1] <= x[i] - (y[i] >>> K);
          y[i+1] <= y[i] + (x[i] >>> K);
          z[i+1] <= z[i] - ATN;
        end
      end
    end
  end

  assign angle = zf[STAGES] ? '0 : z[STAGES];

endmodule

/* hw/rtl/gcdb_checker.sv */
module gcdb_checker #(
  parameter int ANGLE_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  localparam logic [16:0] HALF_UNITS =
    17'(ANGLE_BITS > 16 ? 65535 : (1 << (ANGLE_BITS - 1)));
  localparam logic [15:0] QTR_UNITS = 16'(64'd1 << (ANGLE_BITS - 2));

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  a_central_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> {1'b0, m_axis_tdata[15:0]} <= HALF_UNITS)
    else $error("central angle beyond half a turn");

  a_azimuth: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[47:32] == 16'(QTR_UNITS - m_axis_tdata[31:16]))
    else $error("azimuth does not match initial bearing");

endmodule

bind great_circle_distance_bearing gcdb_checker #(.ANGLE_BITS(ANGLE_BITS)) u_gcdb_checker (
  .clk(clk),
  .rst(rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
